[sv/bracket_match_checker_with_location_top_assert.svh]
// Assertion macros used by the bracket match checker RTL.
`ifndef BRACKET_MATCH_CHECKER_WITH_LOCATION_TOP_ASSERT_SVH
`define BRACKET_MATCH_CHECKER_WITH_LOCATION_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define BMC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bracket checker assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define BMC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bracket checker assertion failed");

`endif

[sv/bmc_pkg.sv]
// Package with the types, constants and codes of the bracket match checker.
package bmc_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int TAB_STOP    = 8;

  localparam int LINE_W  = 20;
  localparam int COL_W   = 16;
  localparam int DEPTH_W = 16;
  localparam int KIND_W  = 2;
  localparam int ENTRY_W = LINE_W + COL_W;

  localparam int ADDR_W = $clog2(STACK_DEPTH);
  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int PH_W   = $clog2(TAB_STOP + 1);

  localparam logic [LINE_W-1:0]  LINE_MAX  = '1;
  localparam logic [COL_W-1:0]   COL_MAX   = '1;
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

  // Tab phase of a column that has reached its ceiling.
  localparam int               COL_SAT_PH_I = 65535 % TAB_STOP;
  localparam logic [PH_W-1:0]  COL_SAT_PH   = PH_W'(COL_SAT_PH_I);
  localparam logic [PH_W-1:0]  PH_LAST      = PH_W'(TAB_STOP - 1);

  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_TAB     = 8'h09;
  localparam logic [7:0] CHAR_OPEN    = 8'h5B;
  localparam logic [7:0] CHAR_CLOSE   = 8'h5D;

  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_EOT  = 1'b1;

  localparam logic [KIND_W-1:0] KIND_CLOSE    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_OPEN     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_OVERFLOW = 2'd2;
  localparam logic [KIND_W-1:0] KIND_DONE     = 2'd3;

  typedef struct packed {
    logic       req_type;
    logic [7:0] char_code;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0] error_kind;
    logic [LINE_W-1:0] line_number;
    logic [COL_W-1:0]  column_number;
    logic              last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [LINE_W-1:0] ent_line;
    logic [COL_W-1:0]  ent_col;
  } stack_entry_t;

endpackage

[sv/bracket_match_checker_with_location_top.sv]
// Bracket match checker: tracks line and column of a byte stream and reports bracket errors.
//
// Input channel (in_valid / in_ready / in_data): one source byte or an end-of-text
// marker per transfer. Output channel (out_valid / out_ready / out_data): error
// reports, each a kind plus line and column, with last_of_run on the final report
// that an input transfer causes.
// An ordinary byte, newline, tab or bracket is handled in the idle state; a byte can
// be taken every cycle while the receiver keeps up and no end-of-text walk runs. An
// unmatched close or a stack overflow is reported on the cycle after its byte is taken.
// End of text walks the open-bracket memory from the bottom up: each stored open
// is read from the memory, then loaded into the output register, and a done report
// follows the last one. No byte is taken during this walk.
// Input is taken only while the output register is empty or being emptied, so a
// stalled receiver holds off the sender without losing any report.
// Synchronous reset puts the location at line 1, column 0 with nothing open. The
// stack memory needs no clearing: only entries pushed since the last end of text
// are ever read.
module bracket_match_checker_with_location_top
  import bmc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

`include "bracket_match_checker_with_location_top_assert.svh"

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]         state_r, state_nxt;
  logic [LINE_W-1:0]  line_r, line_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [PH_W-1:0]    ph_r, ph_nxt;
  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  logic [CNT_W-1:0]   idx_r, idx_nxt;
  logic [CNT_W-1:0]   stored_r, stored_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r, out_data_nxt;

  logic               out_free;
  logic               byte_acc;
  logic               eot_acc;
  logic               below_cap;
  logic [COL_W-1:0]   col_inc;
  logic [PH_W-1:0]    ph_inc;
  logic [COL_W+1:0]   tab_sum;
  logic [CNT_W-1:0]   idx_inc;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  stack_entry_t       ram_wdata;
  logic               ram_re;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [ENTRY_W-1:0] ram_rbits;
  stack_entry_t       ram_rentry;

  bmc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rbits)
  );

  assign ram_rentry = stack_entry_t'(ram_rbits);

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE) && out_free;
  assign byte_acc  = in_valid && in_ready && (in_data.req_type == REQ_BYTE);
  assign eot_acc   = in_valid && in_ready && (in_data.req_type == REQ_EOT);
  assign below_cap = depth_r < DEPTH_W'(STACK_DEPTH);
  assign idx_inc   = idx_r + 1'b1;

  // Column after the per-byte advance; the tab phase follows it modulo the tab width.
  assign col_inc = (col_r == COL_MAX) ? col_r : col_r + 1'b1;
  always_comb begin
    if (col_r == COL_MAX) begin
      ph_inc = ph_r;
    end else if (ph_r == PH_LAST) begin
      ph_inc = '0;
    end else begin
      ph_inc = ph_r + 1'b1;
    end
  end
  assign tab_sum = {2'b00, col_inc} - (COL_W+2)'(ph_inc) + (COL_W+2)'(TAB_STOP);

  always_comb begin
    state_nxt     = state_r;
    line_nxt      = line_r;
    col_nxt       = col_r;
    ph_nxt        = ph_r;
    depth_nxt     = depth_r;
    idx_nxt       = idx_r;
    stored_nxt    = stored_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = depth_r[ADDR_W-1:0];
    ram_wdata     = '{ent_line: line_r, ent_col: col_inc};
    ram_re        = 1'b0;
    ram_raddr     = idx_r[ADDR_W-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (byte_acc) begin
          col_nxt = col_inc;
          ph_nxt  = ph_inc;
          priority if (in_data.char_code == CHAR_NEWLINE) begin
            if (line_r != LINE_MAX) begin
              line_nxt = line_r + 1'b1;
            end
            col_nxt = '0;
            ph_nxt  = '0;
          end else if (in_data.char_code == CHAR_TAB) begin
            if (tab_sum > (COL_W+2)'(COL_MAX)) begin
              col_nxt = COL_MAX;
              ph_nxt  = COL_SAT_PH;
            end else begin
              col_nxt = tab_sum[COL_W-1:0];
              ph_nxt  = '0;
            end
          end else if (in_data.char_code == CHAR_OPEN) begin
            if (below_cap) begin
              ram_we = 1'b1;
            end else begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = '{error_kind: KIND_OVERFLOW, line_number: line_r,
                                column_number: col_inc, last_of_run: 1'b1};
            end
            if (depth_r != DEPTH_MAX) begin
              depth_nxt = depth_r + 1'b1;
            end
          end else if (in_data.char_code == CHAR_CLOSE) begin
            if (depth_r != '0) begin
              depth_nxt = depth_r - 1'b1;
            end else begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = '{error_kind: KIND_CLOSE, line_number: line_r,
                                column_number: col_inc, last_of_run: 1'b1};
            end
          end else begin
            // Ordinary byte: only the column moves.
          end
        end else if (eot_acc) begin
          idx_nxt    = '0;
          stored_nxt = below_cap ? depth_r[CNT_W-1:0] : CNT_W'(STACK_DEPTH);
          state_nxt  = (depth_r == '0) ? ST_DONE : ST_RD;
        end
      end
      ST_RD: begin
        ram_re    = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{error_kind: KIND_OPEN, line_number: ram_rentry.ent_line,
                            column_number: ram_rentry.ent_col, last_of_run: 1'b0};
          idx_nxt       = idx_inc;
          state_nxt     = (idx_inc == stored_r) ? ST_DONE : ST_RD;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{error_kind: KIND_DONE, line_number: '0,
                            column_number: '0, last_of_run: 1'b1};
          line_nxt      = LINE_W'(1);
          col_nxt       = '0;
          ph_nxt        = '0;
          depth_nxt     = '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      line_r      <= LINE_W'(1);
      col_r       <= '0;
      ph_r        <= '0;
      depth_r     <= '0;
      idx_r       <= '0;
      stored_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      line_r      <= line_nxt;
      col_r       <= col_nxt;
      ph_r        <= ph_nxt;
      depth_r     <= depth_nxt;
      idx_r       <= idx_nxt;
      stored_r    <= stored_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A push never lands beyond the memory.
  `BMC_ASSERT_NOW(a_push_fits, ram_we, below_cap)
  // Only open-bracket reports in the end-of-text walk leave last_of_run clear.
  `BMC_ASSERT_NOW(a_last_flag, out_valid, out_data.last_of_run == (out_data.error_kind != KIND_OPEN))
  // The walk never reads past the stored entries.
  `BMC_ASSERT_NOW(a_walk_bound, state_r == ST_RD || state_r == ST_OUT, idx_r < stored_r)
  // End of text stops further input until the walk has finished.
  `BMC_ASSERT_NEXT(a_eot_blocks, eot_acc, !in_ready)

endmodule

[sv/bmc_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module bmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
